/* src/mpsgi_pkg.sv */
package mpsgi_pkg;

    // Default width of stream byte offsets
    localparam int DEF_OFFSET_WIDTH = 48;

    // Scanner phases
    localparam logic [2:0] PH_SCAN   = 3'd0;
    localparam logic [2:0] PH_GOP    = 3'd1;
    localparam logic [2:0] PH_LEN_HI = 3'd2;
    localparam logic [2:0] PH_LEN_LO = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;

    // Start code prefix and the codes acted upon
    localparam logic [23:0] START_PREFIX = 24'h000001;
    localparam logic [7:0]  CODE_PICTURE = 8'h00;
    localparam logic [7:0]  CODE_GOP     = 8'hB8;
    localparam logic [7:0]  CODE_PACK    = 8'hBA;
    localparam logic [7:0]  CODE_SKIP_LO = 8'hBB;
    localparam logic [7:0]  CODE_VID_LO  = 8'hE0;
    localparam logic [7:0]  CODE_VID_HI  = 8'hEF;

    // Number of time code bytes after a GOP start
    localparam logic [2:0]  GOP_BYTES    = 3'd4;

    // GOP time code of one index entry
    typedef struct packed {
        logic [31:0] frames_before;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [5:0]  pictures;
    } gop_entry_t;

endpackage

/* src/mpsgi_core.sv */
// Start code scanner: holds the stream state and works through one byte
// per transfer, flagging an index entry on the last GOP time code byte.
module mpsgi_core
    import mpsgi_pkg::*;
#(
    parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_fire,
    input  logic [7:0]              byte_in,
    input  logic                    cfg_we,
    input  logic [OFFSET_WIDTH-1:0] cfg_offset,
    output logic                    entry_valid,
    output gop_entry_t              entry,
    output logic [OFFSET_WIDTH-1:0] entry_pack_offset
);

    logic [31:0]             tail_reg, tail_next;
    logic [OFFSET_WIDTH-1:0] byte_pos_reg, byte_pos_next;
    logic [31:0]             pic_count_reg, pic_count_next;
    logic [OFFSET_WIDTH-1:0] last_pack_reg, last_pack_next;
    logic [2:0]              phase_reg, phase_next;
    logic [15:0]             skip_reg, skip_next;
    logic [7:0]              len_hi_reg, len_hi_next;
    logic [31:0]             gop_reg, gop_next;
    logic [2:0]              gop_cnt_reg, gop_cnt_next;

    logic [31:0] tail_shift;
    logic [31:0] gop_shift;
    logic [2:0]  gop_cnt_inc;
    logic [15:0] skip_dec;
    logic        code_hit;
    logic        emit;

    assign tail_shift  = {tail_reg[23:0], byte_in};
    assign gop_shift   = {gop_reg[23:0], byte_in};
    assign gop_cnt_inc = gop_cnt_reg + 3'd1;
    assign skip_dec    = skip_reg - 16'd1;
    assign code_hit    = (tail_shift[31:8] == START_PREFIX);

    // Next state for one byte
    always_comb
    begin
        tail_next      = tail_reg;
        pic_count_next = pic_count_reg;
        last_pack_next = last_pack_reg;
        phase_next     = phase_reg;
        skip_next      = skip_reg;
        len_hi_next    = len_hi_reg;
        gop_next       = gop_reg;
        gop_cnt_next   = gop_cnt_reg;
        emit           = 1'b0;

        unique case (phase_reg)
            PH_LEN_HI:
            begin
                len_hi_next = byte_in;
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                skip_next  = {len_hi_reg, byte_in};
                phase_next = ({len_hi_reg, byte_in} == 16'd0) ? PH_SCAN : PH_SKIP;
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    phase_next = PH_SCAN;
                end
            end
            default:
            begin
                tail_next  = tail_shift;
                phase_next = PH_SCAN;
                if (phase_reg == PH_GOP)
                begin
                    gop_next     = gop_shift;
                    gop_cnt_next = gop_cnt_inc;
                    phase_next   = PH_GOP;
                    if (gop_cnt_inc >= GOP_BYTES)
                    begin
                        emit         = 1'b1;
                        phase_next   = PH_SCAN;
                        gop_cnt_next = 3'd0;
                    end
                end

                // Start code handling, after any entry went out
                if (code_hit)
                begin
                    if (byte_in == CODE_PACK)
                    begin
                        last_pack_next = byte_pos_reg - OFFSET_WIDTH'(3);
                    end
                    else if (byte_in == CODE_GOP)
                    begin
                        phase_next   = PH_GOP;
                        gop_cnt_next = 3'd0;
                        gop_next     = 32'd0;
                    end
                    else if (byte_in == CODE_PICTURE)
                    begin
                        pic_count_next = pic_count_reg + 32'd1;
                    end
                    else if (byte_in >= CODE_SKIP_LO &&
                             !(byte_in >= CODE_VID_LO && byte_in <= CODE_VID_HI))
                    begin
                        tail_next  = 32'hFFFF_FFFF;
                        phase_next = PH_LEN_HI;
                    end
                end
            end
        endcase
    end

    assign byte_pos_next = byte_pos_reg + OFFSET_WIDTH'(1);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg      <= 32'hFFFF_FFFF;
            byte_pos_reg  <= '0;
            pic_count_reg <= 32'd0;
            last_pack_reg <= '0;
            phase_reg     <= PH_SCAN;
            skip_reg      <= 16'd0;
            len_hi_reg    <= 8'd0;
            gop_reg       <= 32'd0;
            gop_cnt_reg   <= 3'd0;
        end
        else if (cfg_we)
        begin
            byte_pos_reg <= cfg_offset;
        end
        else if (byte_fire)
        begin
            tail_reg      <= tail_next;
            byte_pos_reg  <= byte_pos_next;
            pic_count_reg <= pic_count_next;
            last_pack_reg <= last_pack_next;
            phase_reg     <= phase_next;
            skip_reg      <= skip_next;
            len_hi_reg    <= len_hi_next;
            gop_reg       <= gop_next;
            gop_cnt_reg   <= gop_cnt_next;
        end
    end

    // Entry fields, counts as they stood before this byte's code
    assign entry_valid            = byte_fire & emit;
    assign entry.frames_before    = pic_count_reg;
    assign entry.hours            = gop_shift[30:26];
    assign entry.minutes          = gop_shift[25:20];
    assign entry.seconds          = gop_shift[18:13];
    assign entry.pictures         = gop_shift[12:7];
    assign entry_pack_offset      = last_pack_reg;

endmodule

/* src/mpsgi_out_stage.sv */
// Result register: holds one index entry until the sink takes it.
module mpsgi_out_stage
    import mpsgi_pkg::*;
#(
    parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic                    entry_valid,
    input  gop_entry_t              entry,
    input  logic [OFFSET_WIDTH-1:0] entry_pack_offset,
    output logic                    out_valid,
    output gop_entry_t              held_entry,
    output logic [OFFSET_WIDTH-1:0] held_pack_offset
);

    logic                    valid_reg;
    gop_entry_t              entry_reg;
    logic [OFFSET_WIDTH-1:0] pack_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= entry_valid;
        end
    end

    // Payload, loaded only with a new entry
    always_ff @(posedge clk)
    begin
        if (advance && entry_valid)
        begin
            entry_reg <= entry;
            pack_reg  <= entry_pack_offset;
        end
    end

    assign out_valid        = valid_reg;
    assign held_entry       = entry_reg;
    assign held_pack_offset = pack_reg;

endmodule

/* src/mpeg_ps_gop_indexer.sv */
// MPEG-2 program stream GOP indexer. Takes one stream byte per transfer on
// the input channel and, on the fourth time code byte after each GOP start
// code, gives one index entry: picture start codes seen so far, the GOP time
// code and the offset of the latest pack start prefix. A byte is taken in
// every cycle unless the input stalls; each byte passes an input register
// and the scanner logic into the result register. Input stalls only while
// a finished entry waits and the sink stalls.
// Writing start_offset (while idle) sets the stream offset of the next byte
// and keeps all other scanner state.
module mpeg_ps_gop_indexer
    import mpsgi_pkg::*;
#(
    parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              stream_byte,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [31:0]             frames_before,
    output logic [4:0]              gop_hours,
    output logic [5:0]              gop_minutes,
    output logic [5:0]              gop_seconds,
    output logic [5:0]              gop_pictures,
    output logic [OFFSET_WIDTH-1:0] pack_offset,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [OFFSET_WIDTH-1:0] start_offset
);

    logic                    byte_valid_reg;
    logic [7:0]              byte_reg;
    logic                    advance;
    logic                    entry_valid;
    gop_entry_t              entry;
    gop_entry_t              held_entry;
    logic [OFFSET_WIDTH-1:0] entry_pack_offset;

    // Pipeline moves unless a held entry is blocked
    assign advance   = !out_valid || !out_stall;
    assign in_stall  = !advance;
    assign cfg_ready = !byte_valid_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            byte_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            byte_reg <= stream_byte;
        end
    end

    mpsgi_core #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .byte_fire         (byte_valid_reg && advance),
        .byte_in           (byte_reg),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_offset        (start_offset),
        .entry_valid       (entry_valid),
        .entry             (entry),
        .entry_pack_offset (entry_pack_offset)
    );

    mpsgi_out_stage #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_out (
        .clk               (clk),
        .rst_n             (rst_n),
        .advance           (advance),
        .entry_valid       (entry_valid),
        .entry             (entry),
        .entry_pack_offset (entry_pack_offset),
        .out_valid         (out_valid),
        .held_entry        (held_entry),
        .held_pack_offset  (pack_offset)
    );

    assign frames_before = held_entry.frames_before;
    assign gop_hours     = held_entry.hours;
    assign gop_minutes   = held_entry.minutes;
    assign gop_seconds   = held_entry.seconds;
    assign gop_pictures  = held_entry.pictures;

endmodule

/* tb/sv/mpeg_ps_gop_indexer_tb.sv */
module mpeg_ps_gop_indexer_tb;
    import mpsgi_pkg::*;

    localparam int OW           = DEF_OFFSET_WIDTH;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_BYTES = 1420;
    localparam int LONG_SKIP    = 300;

    // One index entry as it leaves the block
    typedef struct {
        logic [31:0]   frames;
        logic [4:0]    hours;
        logic [5:0]    minutes;
        logic [5:0]    seconds;
        logic [5:0]    pictures;
        logic [OW-1:0] pack;
    } gop_index_t;

    logic          clk          = 1'b0;
    logic          rst_n        = 1'b0;
    logic          in_valid     = 1'b0;
    logic          in_stall;
    logic [7:0]    stream_byte  = 8'h00;
    logic          out_valid;
    logic          out_stall    = 1'b0;
    logic [31:0]   frames_before;
    logic [4:0]    gop_hours;
    logic [5:0]    gop_minutes;
    logic [5:0]    gop_seconds;
    logic [5:0]    gop_pictures;
    logic [OW-1:0] pack_offset;
    logic          cfg_valid    = 1'b0;
    logic          cfg_ready;
    logic [OW-1:0] start_offset = '0;

    // Scanner state as the testbench tracks it
    logic [31:0]   tail_window;
    logic [OW-1:0] byte_pos;
    logic [31:0]   pic_count;
    logic [OW-1:0] pack_pos;
    logic [2:0]    scan_phase;
    logic [15:0]   skip_left;
    logic [7:0]    len_msb;
    logic [31:0]   tc_word;
    logic [2:0]    tc_count;

    gop_index_t    index_q[$];
    gop_index_t    sink_want;
    int            sink_hold  = 0;
    int            err_cnt    = 0;
    int            sent_total = 0;
    bit            feed_eager = 1'b0;
    bit            sink_eager = 1'b0;

    mpeg_ps_gop_indexer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .stream_byte   (stream_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frames_before (frames_before),
        .gop_hours     (gop_hours),
        .gop_minutes   (gop_minutes),
        .gop_seconds   (gop_seconds),
        .gop_pictures  (gop_pictures),
        .pack_offset   (pack_offset),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .start_offset  (start_offset)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("[mpeg_ps_gop_indexer] ERROR");
        $finish;
    end

    // Advance the tracked scanner by one byte; queue an entry when a time code completes
    task automatic track_byte(input logic [7:0] b);
        gop_index_t e;
        case (scan_phase)
            PH_LEN_HI:
            begin
                len_msb    = b;
                scan_phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                skip_left  = {len_msb, b};
                scan_phase = (skip_left == 16'd0) ? PH_SCAN : PH_SKIP;
            end
            PH_SKIP:
            begin
                skip_left = skip_left - 16'd1;
                if (skip_left == 16'd0)
                    scan_phase = PH_SCAN;
            end
            default:
            begin
                tail_window = {tail_window[23:0], b};
                if (scan_phase == PH_GOP)
                begin
                    tc_word  = {tc_word[23:0], b};
                    tc_count = tc_count + 3'd1;
                    if (tc_count >= GOP_BYTES)
                    begin
                        e.frames   = pic_count;
                        e.hours    = tc_word[30:26];
                        e.minutes  = tc_word[25:20];
                        e.seconds  = tc_word[18:13];
                        e.pictures = tc_word[12:7];
                        e.pack     = pack_pos;
                        index_q.push_back(e);
                        scan_phase = PH_SCAN;
                        tc_count   = 3'd0;
                    end
                end
                else
                begin
                    scan_phase = PH_SCAN;
                end
                // entry goes out first, then a code ending on the last time code byte
                if (tail_window[31:8] == START_PREFIX)
                begin
                    if (b == CODE_PACK)
                        pack_pos = byte_pos - OW'(3);
                    else if (b == CODE_GOP)
                    begin
                        scan_phase = PH_GOP;
                        tc_count   = 3'd0;
                        tc_word    = '0;
                    end
                    else if (b == CODE_PICTURE)
                        pic_count = pic_count + 32'd1;
                    else if (b >= CODE_SKIP_LO && !(b >= CODE_VID_LO && b <= CODE_VID_HI))
                    begin
                        tail_window = '1;
                        scan_phase  = PH_LEN_HI;
                    end
                end
            end
        endcase
        byte_pos = byte_pos + OW'(1);
    endtask

    // One byte transfer on the input channel, with a random lead-in gap
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = feed_eager ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        stream_byte <= b;
        do @(posedge clk); while (in_stall);
        track_byte(b);
        sent_total++;
    endtask

    task automatic send_code(input logic [7:0] code);
        send_byte(START_PREFIX[23:16]);
        send_byte(START_PREFIX[15:8]);
        send_byte(START_PREFIX[7:0]);
        send_byte(code);
    endtask

    // Random bytes leaning towards prefix bytes so stray codes turn up
    function automatic logic [7:0] biased_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick < 2)
            return START_PREFIX[23:16];
        else if (pick == 2)
            return START_PREFIX[7:0];
        return 8'($urandom);
    endfunction

    task automatic send_noise(input int n);
        repeat (n) send_byte(biased_byte());
    endtask

    // Hold the sender off until every entry is back and the pipeline is empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (index_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_start_offset(input logic [OW-1:0] value);
        wait_idle();
        cfg_valid    <= 1'b1;
        start_offset <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        byte_pos  = value;
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Result side: check each transfer, then draw a stall for the next one
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            sink_hold = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (index_q.size() == 0)
                begin
                    $error("index entry with none outstanding");
                    err_cnt++;
                end
                else
                begin
                    sink_want = index_q.pop_front();
                    compare_field("frames_before", 64'(sink_want.frames),
                                  64'(frames_before));
                    compare_field("gop_hours", 64'(sink_want.hours), 64'(gop_hours));
                    compare_field("gop_minutes", 64'(sink_want.minutes), 64'(gop_minutes));
                    compare_field("gop_seconds", 64'(sink_want.seconds), 64'(gop_seconds));
                    compare_field("gop_pictures", 64'(sink_want.pictures),
                                  64'(gop_pictures));
                    compare_field("pack_offset", 64'(sink_want.pack), 64'(pack_offset));
                end
                sink_hold = sink_eager ? 0 : $urandom_range(0, 7);
            end
            else if (sink_hold != 0)
                sink_hold--;
            else if (!sink_eager && $urandom_range(0, 15) == 0)
                sink_hold = $urandom_range(1, 7);
            out_stall <= (sink_hold != 0);
        end
    end

    // Time code fields at all ones and all zeros
    task automatic test_time_code_extremes();
        send_code(CODE_GOP);
        repeat (4) send_byte(8'hFF);
        send_code(CODE_GOP);
        repeat (4) send_byte(8'h00);
    endtask

    // Start codes that end on the last time code byte
    task automatic test_code_in_gop();
        send_code(CODE_GOP);
        send_code(CODE_PICTURE);
        send_code(CODE_GOP);
        send_code(CODE_GOP);
        send_code(CODE_PACK);
        send_code(CODE_GOP);
        send_code(8'hC0);
        // zero length: scanning resumes straight away
        send_byte(8'h00);
        send_byte(8'h00);
        send_code(CODE_GOP);
        send_byte(8'h5A);
        send_byte(8'hC3);
        send_byte(8'h3C);
        send_byte(8'hA5);
    endtask

    // Skipped packets hide their payload; video and low codes are scanned through
    task automatic test_skip_and_video();
        send_code(CODE_VID_HI);
        send_code(CODE_PICTURE);
        send_code(8'hB9);
        send_code(8'hFF);
        send_byte(8'h00);
        send_byte(8'h04);
        send_code(CODE_GOP);
        send_code(CODE_SKIP_LO);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(CODE_PICTURE);
        send_code(CODE_VID_LO);
        send_code(CODE_GOP);
        send_noise(4);
    endtask

    // Offsets at both ends of the range, including a pack prefix that wraps
    task automatic test_offset_wrap();
        write_start_offset('1);
        send_code(CODE_PACK);
        send_code(CODE_GOP);
        send_noise(4);
        send_byte(START_PREFIX[23:16]);
        send_byte(START_PREFIX[15:8]);
        write_start_offset('0);
        send_byte(START_PREFIX[7:0]);
        send_byte(CODE_PACK);
        send_code(CODE_GOP);
        send_noise(4);
        write_start_offset(OW'({$urandom, $urandom}));
        send_code(CODE_PACK);
        send_code(CODE_GOP);
        send_noise(4);
    endtask

    // One random piece of stream: mostly well-formed, some broken or noise
    task automatic send_segment();
        int          kind;
        logic [7:0]  code;
        logic [15:0] len;
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            send_code(CODE_PACK);
            send_noise($urandom_range(0, 10));
        end
        else if (kind < 35)
        begin
            send_code(CODE_PICTURE);
            send_noise($urandom_range(0, 6));
        end
        else if (kind < 55)
        begin
            send_code(CODE_GOP);
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       send_code(CODE_PICTURE);
                    1:       send_code(CODE_GOP);
                    2:       send_code(CODE_PACK);
                    default: send_code(8'($urandom));
                endcase
            end
            else
            begin
                repeat (4) send_byte(8'($urandom));
            end
        end
        else if (kind < 70)
        begin
            do code = 8'($urandom_range(CODE_SKIP_LO, 255));
            while (code >= CODE_VID_LO && code <= CODE_VID_HI);
            case ($urandom_range(0, 19))
                0, 1:    len = 16'd0;
                2:       len = 16'($urandom_range(21, 600));
                default: len = 16'($urandom_range(1, 20));
            endcase
            send_code(code);
            send_byte(len[15:8]);
            send_byte(len[7:0]);
            send_noise(int'(len));
        end
        else if (kind < 78)
        begin
            send_code(CODE_VID_LO + 8'($urandom_range(0, 15)));
            send_noise($urandom_range(0, 6));
        end
        else if (kind < 88)
        begin
            // truncated or padded prefixes
            send_byte(START_PREFIX[23:16]);
            if ($urandom_range(0, 1) != 0)
                send_byte(START_PREFIX[15:8]);
            if ($urandom_range(0, 1) != 0)
                send_byte(START_PREFIX[23:16]);
            send_byte(biased_byte());
        end
        else
        begin
            send_noise($urandom_range(1, 8));
        end
    endtask

    task automatic test_random_stream();
        int base;
        int cfg_done;
        bit long_done;
        base      = sent_total;
        cfg_done  = 0;
        long_done = 1'b0;
        while (sent_total - base < RANDOM_BYTES)
        begin
            feed_eager = ($urandom_range(0, 7) == 0);
            sink_eager = ($urandom_range(0, 7) == 0);
            send_segment();
            // one long skip with a non-zero high length byte, sent back to back
            if (!long_done && scan_phase == PH_SCAN
                && sent_total - base > RANDOM_BYTES / 2)
            begin
                long_done  = 1'b1;
                feed_eager = 1'b1;
                send_code(8'hBE);
                send_byte(8'(LONG_SKIP >> 8));
                send_byte(8'(LONG_SKIP));
                repeat (LONG_SKIP) send_byte(biased_byte());
                feed_eager = 1'b0;
                send_code(CODE_GOP);
                send_noise(4);
            end
            // change the offset a few times along the way
            if (cfg_done < 3 && sent_total - base > (cfg_done + 1) * RANDOM_BYTES / 4)
            begin
                cfg_done++;
                if (cfg_done == 2)
                    write_start_offset('0);
                else
                    write_start_offset(OW'({$urandom, $urandom}));
            end
        end
        feed_eager = 1'b0;
        sink_eager = 1'b0;
    endtask

    initial
    begin
        tail_window = '1;
        byte_pos    = '0;
        pic_count   = '0;
        pack_pos    = '0;
        scan_phase  = PH_SCAN;
        skip_left   = '0;
        len_msb     = '0;
        tc_word     = '0;
        tc_count    = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_time_code_extremes();
        test_code_in_gop();
        test_skip_and_video();
        test_offset_wrap();
        test_random_stream();
        wait_idle();
        if (err_cnt == 0)
            $display("[mpeg_ps_gop_indexer] OK");
        else
            $display("[mpeg_ps_gop_indexer] ERROR");
        $finish;
    end

endmodule
